/* hdl/rid_pkg.sv */
// shared types and constants of the in-range interval detector
package rid_pkg;

  // field widths fixed by the record formats
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned CFG_IDX_W = 3;

  // request types
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_EOD    = 1'b1;

  // result kinds
  localparam logic KIND_INTERVAL = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_EN  = 3'd4;

  // input request
  typedef struct packed {
    logic                      req_type;
    logic [TIME_W-1:0]         time_stamp;
    logic signed [VALUE_W-1:0] sample_value;
  } in_item_t;

  // result record
  typedef struct packed {
    logic               result_kind;
    logic [TIME_W-1:0]  interval_start;
    logic [TIME_W-1:0]  interval_end;
    logic               truncated;
    logic [COUNT_W-1:0] interval_count;
    logic [SUM_W-1:0]   summed_duration;
    logic [TIME_W-1:0]  trial_span;
    logic               last;
  } out_item_t;

  // operands of the shared subtract and compare unit
  typedef struct packed {
    logic [TIME_W-1:0] x;
    logic [TIME_W-1:0] y;
    logic [TIME_W-1:0] z;
  } alu_req_t;

  // results of the shared unit: x - y, x >= y, (x - y) >= z
  typedef struct packed {
    logic [TIME_W-1:0] diff;
    logic              geq;
    logic              ge_z;
  } alu_rsp_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SPLIT,
    ST_CLOSE,
    ST_SUM
  } state_t;

endpackage

/* hdl/rid_alu.sv */
// shared time subtractor with borrow and length compare
module rid_alu (
  input  rid_pkg::alu_req_t req,
  output rid_pkg::alu_rsp_t rsp
);

  logic [rid_pkg::TIME_W:0] diff_full;

  // subtract with borrow out, then compare the difference
  always_comb begin
    diff_full = {1'b0, req.x} - {1'b0, req.y};
    rsp.diff  = diff_full[rid_pkg::TIME_W-1:0];
    rsp.geq   = ~diff_full[rid_pkg::TIME_W];
    rsp.ge_z  = diff_full[rid_pkg::TIME_W-1:0] >= req.z;
  end

endmodule

/* hdl/in_range_interval_detector.sv */
// in-range interval detector top level: sequencer, state and output register
// Each request is taken into a holding register and worked off by a small
// sequencer around one shared subtract-and-compare unit; in_stall is high
// until the request is done. An in-range sample without a split needs only
// ST_EVAL, an out-of-range sample ST_EVAL and ST_CLOSE whether or not it
// closes a run, a sample crossing split windows ST_EVAL and ST_SPLIT, where
// the shared unit gives n windows (n at most MAX_SPLITS), one window per
// cycle unless stalled; end of data needs ST_EVAL, ST_CLOSE and ST_SUM.
// Results wait while out_stall holds the single output register. Configuration
// writes take effect at once; issue them only while no request is in flight.
module in_range_interval_detector #(
  parameter int unsigned MAX_SPLITS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rid_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rid_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [rid_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rid_pkg::TIME_W-1:0]          cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(MAX_SPLITS + 1);
  localparam int unsigned LIM_W = rid_pkg::TIME_W + $clog2(MAX_SPLITS + 2);

  // configuration registers
  logic signed [rid_pkg::VALUE_W-1:0] data_min_r;
  logic signed [rid_pkg::VALUE_W-1:0] data_max_r;
  logic [rid_pkg::TIME_W-1:0]         win_min_r;
  logic [rid_pkg::TIME_W-1:0]         win_max_r;
  logic                               split_en_r;
  logic [LIM_W-1:0]                   lim_r;

  // detector state
  rid_pkg::state_t              state_r, state_nxt;
  rid_pkg::in_item_t            item_r, item_nxt;
  logic                         in_run_r, in_run_nxt;
  logic [rid_pkg::TIME_W-1:0]   run_start_r, run_start_nxt;
  logic [rid_pkg::TIME_W-1:0]   prev_time_r, prev_time_nxt;
  logic [rid_pkg::TIME_W-1:0]   trial_start_r, trial_start_nxt;
  logic                         seen_r, seen_nxt;
  logic [rid_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [rid_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [rid_pkg::TIME_W-1:0]   rem_r, rem_nxt;
  logic                         trunc_r, trunc_nxt;
  logic [CNT_W-1:0]             split_cnt_r, split_cnt_nxt;

  // output register
  logic                         out_valid_r;
  rid_pkg::out_item_t           out_r;

  logic                         out_free;
  logic                         emit;
  rid_pkg::out_item_t           rec;
  logic                         tally_en;
  logic [rid_pkg::TIME_W-1:0]   tally_len;
  logic [rid_pkg::SUM_W:0]      sum_add;
  logic                         in_rng;
  logic                         split_last;
  logic                         close_hit;
  rid_pkg::alu_req_t            alu_req;
  rid_pkg::alu_rsp_t            alu_rsp;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_min_r <= {1'b1, {(rid_pkg::VALUE_W-1){1'b0}}};
      data_max_r <= {1'b0, {(rid_pkg::VALUE_W-1){1'b1}}};
      win_min_r  <= '0;
      win_max_r  <= '0;
      split_en_r <= 1'b0;
      lim_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rid_pkg::CFG_DATA_MIN: data_min_r <= $signed(cfg_wdata);
        rid_pkg::CFG_DATA_MAX: data_max_r <= $signed(cfg_wdata);
        rid_pkg::CFG_WIN_MIN:  win_min_r  <= cfg_wdata;
        // window length and the span beyond which a split burst is cut short
        rid_pkg::CFG_WIN_MAX: begin
          win_max_r <= cfg_wdata;
          lim_r     <= LIM_W'(cfg_wdata) * LIM_W'(MAX_SPLITS + 1);
        end
        rid_pkg::CFG_SPLIT_EN: split_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // operand select for the shared unit
  always_comb begin
    alu_req.x = prev_time_r;
    alu_req.y = run_start_r;
    alu_req.z = win_min_r;
    unique case (state_r)
      rid_pkg::ST_EVAL: begin
        alu_req.x = item_r.time_stamp;
        alu_req.z = win_max_r;
      end
      rid_pkg::ST_SPLIT: begin
        alu_req.x = rem_r;
        alu_req.y = win_max_r;
        alu_req.z = win_max_r;
      end
      rid_pkg::ST_SUM: begin
        alu_req.y = trial_start_r;
        alu_req.z = '0;
      end
      default: ;
    endcase
  end

  rid_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign out_free   = !out_valid_r || !out_stall;
  assign in_rng     = (item_r.sample_value >= data_min_r) &&
                      (item_r.sample_value <= data_max_r);
  assign split_last = !alu_rsp.ge_z || (split_cnt_r == CNT_W'(MAX_SPLITS - 1));
  assign close_hit  = in_run_r && alu_rsp.geq && alu_rsp.ge_z;

  // sequencer: next state and result records
  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    in_run_nxt      = in_run_r;
    run_start_nxt   = run_start_r;
    prev_time_nxt   = prev_time_r;
    trial_start_nxt = trial_start_r;
    seen_nxt        = seen_r;
    rem_nxt         = rem_r;
    trunc_nxt       = trunc_r;
    split_cnt_nxt   = split_cnt_r;
    emit            = 1'b0;
    rec             = '0;
    tally_en        = 1'b0;
    tally_len       = '0;

    unique case (state_r)
      rid_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = rid_pkg::ST_EVAL;
        end
      end

      rid_pkg::ST_EVAL: begin
        if (item_r.req_type == rid_pkg::REQ_EOD) begin
          state_nxt = rid_pkg::ST_CLOSE;
        end else begin
          if (!seen_r) begin
            trial_start_nxt = item_r.time_stamp;
            seen_nxt        = 1'b1;
          end
          if (!in_rng) begin
            state_nxt = rid_pkg::ST_CLOSE;
          end else if (!in_run_r) begin
            run_start_nxt = item_r.time_stamp;
            in_run_nxt    = 1'b1;
            prev_time_nxt = item_r.time_stamp;
            state_nxt     = rid_pkg::ST_IDLE;
          end else if (split_en_r && (win_max_r != '0) && alu_rsp.geq && alu_rsp.ge_z) begin
            rem_nxt       = alu_rsp.diff;
            trunc_nxt     = LIM_W'(alu_rsp.diff) >= lim_r;
            split_cnt_nxt = '0;
            state_nxt     = rid_pkg::ST_SPLIT;
          end else begin
            prev_time_nxt = item_r.time_stamp;
            state_nxt     = rid_pkg::ST_IDLE;
          end
        end
      end

      // one window per cycle if out_free; rem_r holds time left past run start
      rid_pkg::ST_SPLIT: begin
        if (out_free) begin
          emit               = 1'b1;
          rec.result_kind    = rid_pkg::KIND_INTERVAL;
          rec.interval_start = run_start_r;
          rec.interval_end   = run_start_r + win_max_r;
          rec.truncated      = trunc_r;
          rec.last           = split_last;
          tally_en           = 1'b1;
          tally_len          = win_max_r;
          run_start_nxt      = run_start_r + win_max_r;
          rem_nxt            = alu_rsp.diff;
          split_cnt_nxt      = split_cnt_r + CNT_W'(1);
          if (split_last) begin
            prev_time_nxt = item_r.time_stamp;
            state_nxt     = rid_pkg::ST_IDLE;
          end
        end
      end

      // end the open run, reporting it when long enough
      rid_pkg::ST_CLOSE: begin
        if (!close_hit || out_free) begin
          if (close_hit) begin
            emit               = 1'b1;
            rec.result_kind    = rid_pkg::KIND_INTERVAL;
            rec.interval_start = run_start_r;
            rec.interval_end   = prev_time_r;
            rec.last           = (item_r.req_type == rid_pkg::REQ_SAMPLE);
            tally_en           = 1'b1;
            tally_len          = alu_rsp.diff;
          end
          if (item_r.req_type == rid_pkg::REQ_EOD) begin
            state_nxt = rid_pkg::ST_SUM;
          end else begin
            in_run_nxt    = 1'b0;
            prev_time_nxt = item_r.time_stamp;
            state_nxt     = rid_pkg::ST_IDLE;
          end
        end
      end

      // summary record, then clear the trial
      rid_pkg::ST_SUM: begin
        if (out_free) begin
          emit                = 1'b1;
          rec.result_kind     = rid_pkg::KIND_SUMMARY;
          rec.interval_count  = count_r;
          rec.summed_duration = sum_r;
          rec.trial_span      = (seen_r && alu_rsp.geq) ? alu_rsp.diff : '0;
          rec.last            = 1'b1;
          in_run_nxt          = 1'b0;
          run_start_nxt       = '0;
          prev_time_nxt       = '0;
          trial_start_nxt     = '0;
          seen_nxt            = 1'b0;
          state_nxt           = rid_pkg::ST_IDLE;
        end
      end

      default: state_nxt = rid_pkg::ST_IDLE;
    endcase
  end

  // saturating interval count and duration sum, cleared by the summary
  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sum_add   = {1'b0, sum_r} + (rid_pkg::SUM_W + 1)'(tally_len);
    if (state_r == rid_pkg::ST_SUM && out_free) begin
      count_nxt = '0;
      sum_nxt   = '0;
    end else if (tally_en) begin
      if (count_r != '1) begin
        count_nxt = count_r + rid_pkg::COUNT_W'(1);
      end
      sum_nxt = sum_add[rid_pkg::SUM_W] ? '1 : sum_add[rid_pkg::SUM_W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rid_pkg::ST_IDLE;
      in_run_r      <= 1'b0;
      run_start_r   <= '0;
      prev_time_r   <= '0;
      trial_start_r <= '0;
      seen_r        <= 1'b0;
      count_r       <= '0;
      sum_r         <= '0;
      split_cnt_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      in_run_r      <= in_run_nxt;
      run_start_r   <= run_start_nxt;
      prev_time_r   <= prev_time_nxt;
      trial_start_r <= trial_start_nxt;
      seen_r        <= seen_nxt;
      count_r       <= count_nxt;
      sum_r         <= sum_nxt;
      split_cnt_r   <= split_cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    rem_r   <= rem_nxt;
    trunc_r <= trunc_nxt;
    if (emit) begin
      out_r <= rec;
    end
  end

  assign in_stall  = (state_r != rid_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* tb/sv/tb.sv */
// self-checking testbench of the in-range interval detector
`timescale 1ns / 1ps

module tb;

  localparam int MAX_SPLITS    = 64;
  localparam int RANDOM_ITEMS  = 85;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int IDLE_LIMIT    = 2000;

  localparam logic signed [31:0] VAL_LOW  = 32'h8000_0000;
  localparam logic signed [31:0] VAL_HIGH = 32'h7fff_ffff;

  // register settings as the block sees them
  typedef struct {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [31:0]        wmin;
    logic [31:0]        wmax;
    logic               split;
  } settings_t;

  // one row of the directed table
  typedef enum bit {ROW_REQ, ROW_SETUP} row_kind_t;
  typedef struct {
    row_kind_t          kind;
    rid_pkg::in_item_t  req;
    settings_t          setup;
    bit                 typed;
    rid_pkg::out_item_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  rid_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  rid_pkg::out_item_t out_data;
  logic cfg_we;
  logic [rid_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rid_pkg::TIME_W-1:0] cfg_wdata;

  // predicted detector state and live register copy
  settings_t   cur;
  logic        run_open;
  logic [31:0] run_from;
  logic [31:0] last_t;
  logic [31:0] first_t;
  logic        got_sample;
  logic [31:0] done_count;
  logic [39:0] dur_total;

  rid_pkg::out_item_t due_records[$];

  // request-side pinned expectation for typed table rows
  bit                 pin_on;
  rid_pkg::out_item_t pin_rec;

  // coordination between stimulus and receiver
  bit hold_req;
  bit calm;

  // value shaping for random trials
  logic signed [31:0] val_center;
  int                 val_spread;

  int errors;
  int requests_taken;
  int records_seen;
  int windows_cut;
  int setups;
  int idle_cycles;

  in_range_interval_detector #(.MAX_SPLITS(MAX_SPLITS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rid_pkg::out_item_t make_rec(logic kind, logic [31:0] s,
                                                  logic [31:0] e, logic tr,
                                                  logic [31:0] cnt, logic [39:0] sum,
                                                  logic [31:0] dur, logic lst);
    rid_pkg::out_item_t r;
    r.result_kind     = kind;
    r.interval_start  = s;
    r.interval_end    = e;
    r.truncated       = tr;
    r.interval_count  = cnt;
    r.summed_duration = sum;
    r.trial_span      = dur;
    r.last            = lst;
    return r;
  endfunction

  function automatic void clear_trial();
    run_open   = 1'b0;
    run_from   = '0;
    last_t     = '0;
    first_t    = '0;
    got_sample = 1'b0;
    done_count = '0;
    dur_total  = '0;
  endfunction

  // saturating count and duration totals
  function automatic void add_interval(logic [31:0] len);
    logic [40:0] wide;
    if (done_count != 32'hffff_ffff) done_count = done_count + 1;
    wide = {1'b0, dur_total} + len;
    dur_total = wide[40] ? '1 : wide[39:0];
  endfunction

  // closing record of the open run, if long enough
  function automatic bit close_run_rec(output rid_pkg::out_item_t rec);
    rec = '0;
    if (run_open && last_t >= run_from && (last_t - run_from) >= cur.wmin) begin
      add_interval(last_t - run_from);
      rec = make_rec(rid_pkg::KIND_INTERVAL, run_from, last_t, 1'b0, '0, '0, '0, 1'b0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // records one request produces, queued when keep is set
  function automatic void predict_records(input rid_pkg::in_item_t r, input bit keep);
    rid_pkg::out_item_t batch[$];
    rid_pkg::out_item_t rec;
    logic [31:0] t;
    logic [31:0] pend;
    logic [31:0] nwin;
    logic [31:0] stop;
    logic signed [31:0] v;
    logic cut;
    int i;
    t = r.time_stamp;
    v = r.sample_value;
    if (r.req_type == rid_pkg::REQ_EOD) begin
      if (close_run_rec(rec)) batch.push_back(rec);
      batch.push_back(make_rec(rid_pkg::KIND_SUMMARY, '0, '0, 1'b0, done_count, dur_total,
                               (got_sample && last_t >= first_t) ? last_t - first_t : '0,
                               1'b0));
      clear_trial();
    end else begin
      if (!got_sample) begin
        first_t    = t;
        got_sample = 1'b1;
      end
      if (v >= cur.lo && v <= cur.hi) begin
        if (!run_open) begin
          run_from = t;
          run_open = 1'b1;
        end else if (cur.split && cur.wmax != 0 && t >= run_from &&
                     (t - run_from) >= cur.wmax) begin
          // back-to-back windows, capped per sample
          pend = (t - run_from) / cur.wmax;
          nwin = (pend > MAX_SPLITS) ? MAX_SPLITS : pend;
          cut  = (pend > nwin);
          for (i = 0; i < nwin; i++) begin
            stop = run_from + cur.wmax;
            batch.push_back(make_rec(rid_pkg::KIND_INTERVAL, run_from, stop, cut,
                                     '0, '0, '0, 1'b0));
            add_interval(cur.wmax);
            run_from = stop;
          end
        end
      end else begin
        if (close_run_rec(rec)) batch.push_back(rec);
        run_open = 1'b0;
      end
      last_t = t;
    end
    if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
    if (keep) foreach (batch[j]) due_records.push_back(batch[j]);
  endfunction

  task automatic check_field(input string name, input logic [39:0] want,
                             input logic [39:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_record(input rid_pkg::out_item_t want,
                                input rid_pkg::out_item_t got);
    check_field("result_kind", want.result_kind, got.result_kind);
    check_field("interval_start", want.interval_start, got.interval_start);
    check_field("interval_end", want.interval_end, got.interval_end);
    check_field("truncated", want.truncated, got.truncated);
    check_field("interval_count", want.interval_count, got.interval_count);
    check_field("summed_duration", want.summed_duration, got.summed_duration);
    check_field("trial_span", want.trial_span, got.trial_span);
    check_field("last", want.last, got.last);
  endtask

  // result checking and request prediction at the clock edge
  always @(posedge clk) begin : monitor
    rid_pkg::out_item_t want;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        records_seen++;
        if (out_data.truncated === 1'b1) windows_cut++;
        if (due_records.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, got %h", $time, out_data);
        end else begin
          want = due_records.pop_front();
          compare_record(want, out_data);
        end
      end
      if (in_valid && in_stall === 1'b0) begin
        requests_taken++;
        predict_records(in_data, !pin_on);
        if (pin_on) due_records.push_back(pin_rec);
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin : watchdog
    if (rst_n !== 1'b1 || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall == 1'b0))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: nothing moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result receiver: stall bursts, quiet stretches and one long hold-off
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!calm) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            out_stall <= 1'b0;
          end
          2: repeat ($urandom_range(10, 40)) @(negedge clk);
          default: ;
        endcase
      end
    end
  end

  // offer one request, returns at the edge that takes it
  task automatic send_req(input rid_pkg::in_item_t r, input bit typed,
                          input rid_pkg::out_item_t want);
    int gap;
    gap = 0;
    if (!calm && !hold_req && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pin_on  = typed;
    pin_rec = want;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // stop offering and wait until every predicted record has come
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_records.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setup(input settings_t s);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= rid_pkg::CFG_DATA_MIN;
    cfg_wdata <= s.lo;
    @(negedge clk);
    cfg_index <= rid_pkg::CFG_DATA_MAX;
    cfg_wdata <= s.hi;
    @(negedge clk);
    cfg_index <= rid_pkg::CFG_WIN_MIN;
    cfg_wdata <= s.wmin;
    @(negedge clk);
    cfg_index <= rid_pkg::CFG_WIN_MAX;
    cfg_wdata <= s.wmax;
    @(negedge clk);
    cfg_index <= rid_pkg::CFG_SPLIT_EN;
    cfg_wdata <= {31'b0, s.split};
    @(negedge clk);
    cfg_we <= 1'b0;
    cur = s;
    setups++;
  endtask

  function automatic plan_row_t req_row(logic kind, logic [31:0] t, logic signed [31:0] v);
    plan_row_t row;
    row.kind              = ROW_REQ;
    row.req.req_type      = kind;
    row.req.time_stamp    = t;
    row.req.sample_value  = v;
    row.setup             = cur;
    row.typed             = 1'b0;
    row.want              = '0;
    return row;
  endfunction

  function automatic plan_row_t pinned(plan_row_t row, rid_pkg::out_item_t want);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic plan_row_t setup_row(logic signed [31:0] lo, logic signed [31:0] hi,
                                          logic [31:0] wmin, logic [31:0] wmax,
                                          logic split);
    plan_row_t row;
    row = req_row(rid_pkg::REQ_SAMPLE, '0, '0);
    row.kind        = ROW_SETUP;
    row.setup.lo    = lo;
    row.setup.hi    = hi;
    row.setup.wmin  = wmin;
    row.setup.wmax  = wmax;
    row.setup.split = split;
    return row;
  endfunction

  // random register setting, also picks where sample values cluster
  function automatic settings_t rand_settings();
    settings_t s;
    int unsigned hw;
    val_center = $urandom;
    hw         = $urandom_range(0, 1000);
    val_spread = hw;
    case ($urandom_range(0, 9))
      0, 1: begin
        s.lo = VAL_LOW;
        s.hi = VAL_HIGH;
      end
      2: begin
        s.lo = val_center + hw + 1;
        s.hi = val_center - hw;
      end
      default: begin
        s.lo = val_center - hw;
        s.hi = val_center + hw;
      end
    endcase
    s.wmin = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 30);
    case ($urandom_range(0, 5))
      0: s.wmax = '0;
      1: s.wmax = $urandom;
      default: s.wmax = $urandom_range(1, 60);
    endcase
    s.split = ($urandom_range(0, 3) != 0);
    return s;
  endfunction

  initial begin : stimulus
    plan_row_t plan[$];
    rid_pkg::in_item_t r;
    logic [31:0] t;
    logic signed [31:0] v;
    int off;
    int n;
    int k;
    int trial;
    int issued;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_req  = 1'b0;
    calm      = 1'b0;
    pin_on    = 1'b0;
    pin_rec   = '0;
    errors = 0;
    requests_taken = 0;
    records_seen = 0;
    windows_cut = 0;
    setups = 0;
    idle_cycles = 0;
    cur.lo = VAL_LOW;
    cur.hi = VAL_HIGH;
    cur.wmin = '0;
    cur.wmax = '0;
    cur.split = 1'b0;
    clear_trial();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: empty trial, extreme values, end of data with junk fields
    plan.push_back(pinned(req_row(rid_pkg::REQ_EOD, '0, '0),
                          make_rec(rid_pkg::KIND_SUMMARY, '0, '0, 1'b0, '0, '0, '0, 1'b1)));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd0, VAL_LOW));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd5, VAL_HIGH));
    plan.push_back(req_row(rid_pkg::REQ_EOD, 32'hffff_ffff, VAL_LOW));
    // splitting on: windows, short run dropped, truncated bursts, time going back
    plan.push_back(setup_row(-32'sd100, 32'sd100, 32'd3, 32'd10, 1'b1));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd100, 32'sd0));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd125, -32'sd100));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd126, 32'sd101));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd130, 32'sd100));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd131, -32'sd101));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd140, 32'sd5));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd2000, 32'sd5));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd2000, 32'sd5));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd2001, 32'sd5));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd1990, 32'sd5));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd1995, 32'sd200));
    plan.push_back(req_row(rid_pkg::REQ_EOD, 32'd0, 32'sd0));
    // inverted limits, splitting off through zero window, backwards trial
    plan.push_back(setup_row(VAL_HIGH, VAL_LOW, 32'hffff_ffff, 32'd0, 1'b1));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd50, 32'sd0));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd10, VAL_HIGH));
    plan.push_back(pinned(req_row(rid_pkg::REQ_EOD, 32'h1234_5678, VAL_HIGH),
                          make_rec(rid_pkg::KIND_SUMMARY, '0, '0, 1'b0, '0, '0, '0, 1'b1)));
    // single-value range, widest window at the top of time
    plan.push_back(setup_row(32'sd7, 32'sd7, 32'd0, 32'hffff_ffff, 1'b1));
    plan.push_back(req_row(rid_pkg::REQ_SAMPLE, 32'd0, 32'sd7));
    plan.push_back(pinned(req_row(rid_pkg::REQ_SAMPLE, 32'hffff_ffff, 32'sd7),
                          make_rec(rid_pkg::KIND_INTERVAL, '0, 32'hffff_ffff, 1'b0,
                                   '0, '0, '0, 1'b1)));
    plan.push_back(req_row(rid_pkg::REQ_EOD, 32'd0, 32'sd0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SETUP) apply_setup(plan[i].setup);
      else send_req(plan[i].req, plan[i].typed, plan[i].want);
    end

    // random trials: sample runs with random content, each closed by end of data
    trial  = 0;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      if (trial % 2 == 0) apply_setup(rand_settings());
      if (trial == 5) wait_drained();
      if (trial == 2) hold_req = 1'b1;
      if (issued >= RANDOM_ITEMS * 4 / 5) calm = 1'b1;
      n = $urandom_range(2, 12);
      t = $urandom;
      for (k = 0; k < n; k++) begin
        case ($urandom_range(0, 9))
          0: ;
          1: t = t - $urandom_range(1, 20);
          2: t = t + ((cur.wmax != 0 && cur.wmax <= 60) ?
                      $urandom_range(60 * cur.wmax, 140 * cur.wmax) :
                      $urandom_range(200, 3000));
          default: t = t + $urandom_range(1, (cur.wmax != 0 && cur.wmax <= 60) ?
                                             2 * cur.wmax + 5 : 40);
        endcase
        case ($urandom_range(0, 9))
          0: v = $urandom;
          1: v = $urandom_range(0, 1) ? cur.lo : cur.hi;
          2, 3: begin
            off = int'($urandom_range(0, 4 * val_spread + 6)) - (2 * val_spread + 3);
            v = val_center + off;
          end
          default: begin
            off = int'($urandom_range(0, 2 * val_spread)) - val_spread;
            v = val_center + off;
          end
        endcase
        r.req_type     = rid_pkg::REQ_SAMPLE;
        r.time_stamp   = t;
        r.sample_value = v;
        // occasional stray request breaks the sequence
        if ($urandom_range(0, 19) == 0) begin
          r.req_type     = 1'($urandom_range(0, 1));
          r.time_stamp   = $urandom;
          r.sample_value = $urandom;
        end
        send_req(r, 1'b0, '0);
        issued++;
      end
      r.req_type     = rid_pkg::REQ_EOD;
      r.time_stamp   = $urandom;
      r.sample_value = $urandom;
      send_req(r, 1'b0, '0);
      issued++;
      trial++;
    end

    wait_drained();
    $display("run covered %0d requests and %0d result records (%0d cut windows)",
             requests_taken, records_seen, windows_cut);
    $display("over %0d register settings after the reset setting", setups);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
